>>> rtl/bflb_pkg.sv
// package with constants, payload types and control types for the bitmap bit search
`timescale 1ns / 1ps

package bflb_pkg;

    localparam int WORD_BITS = 32;
    localparam int WORDS = 8;

    localparam int OPCODE_W = 3;
    localparam int WORD_INDEX_W = 3;
    localparam int WORD_DATA_W = 32;
    localparam int BIT_COUNT_W = 9;
    localparam int POSITION_W = 8;

    localparam int TOTAL_BITS = WORDS * WORD_BITS;
    localparam int CNT_W = $clog2(TOTAL_BITS + 1);
    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W = $clog2(WORD_BITS);
    localparam int CMP_W = (CNT_W > BIT_COUNT_W) ? CNT_W : BIT_COUNT_W;
    localparam int SUM_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam int WI_W = (IDX_W > WORD_INDEX_W) ? IDX_W : WORD_INDEX_W;
    localparam int WD_W = (WORD_BITS > WORD_DATA_W) ? WORD_BITS : WORD_DATA_W;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_FIRST_SET = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_FIRST_CLEAR = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_LAST_SET = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LAST_CLEAR = 3'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [WORD_DATA_W-1:0]  word_data;
        logic [BIT_COUNT_W-1:0]  bit_count;
    } s_payload_t;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } m_payload_t;

    typedef struct packed {
        logic wr_word;
        logic start_query;
        logic step;
        logic capture;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic last_word;
    } dp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

endpackage

>>> rtl/bflb_ctrl.sv
// controller state machine for the bitmap bit search
`timescale 1ns / 1ps

module bflb_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bflb_pkg::OPCODE_W-1:0]  s_opcode,
    output logic                           m_valid,
    input  logic                           m_ready,
    input  bflb_pkg::dp_status_t           status,
    output bflb_pkg::ctrl_cmd_t            cmd
);
    import bflb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_opcode) inside
                        OP_WRITE: begin
                            cmd.wr_word = 1'b1;
                        end
                        OP_FIRST_SET, OP_FIRST_CLEAR, OP_LAST_SET, OP_LAST_CLEAR: begin
                            cmd.start_query = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (status.hit || status.last_word) begin
                    cmd.capture = 1'b1;
                    state_next = ST_HOLD;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a result waits");

    a_scan_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !status.hit && !status.last_word) |=> state_reg == ST_SCAN)
        else $error("scan left before a match or the last word");

    a_no_step_past_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !status.last_word)
        else $error("scan stepped past the last word");

    a_start_enters_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_query |=> state_reg == ST_SCAN)
        else $error("query start did not enter scan");

endmodule

>>> rtl/bflb_dp.sv
// datapath with the bitmap store, word scanner and result registers
`timescale 1ns / 1ps

module bflb_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bflb_pkg::s_payload_t  s_payload,
    input  bflb_pkg::ctrl_cmd_t   cmd,
    output bflb_pkg::dp_status_t  status,
    output bflb_pkg::m_payload_t  m_payload
);
    import bflb_pkg::*;

    logic [WORD_BITS-1:0] bitmap_reg [WORDS];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     base_reg;
    logic [IDX_W-1:0]     widx_reg;
    logic [IDX_W-1:0]     step_reg;
    logic                 want_set_reg;
    logic                 from_top_reg;
    logic                 res_found_reg;
    logic [POSITION_W-1:0] res_pos_reg;
    m_payload_t           out_reg;

    logic [WI_W-1:0]      wr_idx_ext;
    logic [WD_W-1:0]      wr_data_ext;
    logic                 q_want_set;
    logic                 q_from_top;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] cand;
    logic [CNT_W:0]       base_lim;
    logic [CNT_W-1:0]     rem;
    logic [BIT_W-1:0]     bit_pos;
    logic [SUM_W-1:0]     pos_sum;

    assign wr_idx_ext  = WI_W'(s_payload.word_index);
    assign wr_data_ext = WD_W'(s_payload.word_data);
    assign q_want_set  = (s_payload.opcode == OP_FIRST_SET) || (s_payload.opcode == OP_LAST_SET);
    assign q_from_top  = (s_payload.opcode == OP_LAST_SET) || (s_payload.opcode == OP_LAST_CLEAR);

    always_comb begin
        if (CMP_W'(s_payload.bit_count) > CMP_W'(TOTAL_BITS)) begin
            count_next = CNT_W'(TOTAL_BITS);
        end else begin
            count_next = CNT_W'(s_payload.bit_count);
        end
    end

    // bitmap store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORDS; i++) begin
                bitmap_reg[i] <= '0;
            end
        end else if (cmd.wr_word && ({1'b0, wr_idx_ext} < (WI_W + 1)'(WORDS))) begin
            bitmap_reg[wr_idx_ext[IDX_W-1:0]] <= wr_data_ext[WORD_BITS-1:0];
        end
    end

    // scan position
    always_ff @(posedge aclk) begin
        if (cmd.start_query) begin
            count_reg    <= count_next;
            want_set_reg <= q_want_set;
            from_top_reg <= q_from_top;
            step_reg     <= '0;
            if (q_from_top) begin
                widx_reg <= IDX_W'(WORDS - 1);
                base_reg <= CNT_W'((WORDS - 1) * WORD_BITS);
            end else begin
                widx_reg <= '0;
                base_reg <= '0;
            end
        end else if (cmd.step) begin
            step_reg <= step_reg + IDX_W'(1);
            if (from_top_reg) begin
                widx_reg <= widx_reg - IDX_W'(1);
                base_reg <= base_reg - CNT_W'(WORD_BITS);
            end else begin
                widx_reg <= widx_reg + IDX_W'(1);
                base_reg <= base_reg + CNT_W'(WORD_BITS);
            end
        end
    end

    assign cur_word = bitmap_reg[widx_reg];
    assign base_lim = {1'b0, base_reg} + (CNT_W + 1)'(WORD_BITS);
    assign rem      = count_reg - base_reg;

    always_comb begin
        if ({1'b0, count_reg} >= base_lim) begin
            range_mask = '1;
        end else if (count_reg > base_reg) begin
            range_mask = ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
        end else begin
            range_mask = '0;
        end
    end

    assign cand = (want_set_reg ? cur_word : ~cur_word) & range_mask;

    // lowest or highest candidate bit
    always_comb begin
        bit_pos = '0;
        if (from_top_reg) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                if (cand[b]) begin
                    bit_pos = BIT_W'(b);
                end
            end
        end else begin
            for (int b = WORD_BITS - 1; b >= 0; b--) begin
                if (cand[b]) begin
                    bit_pos = BIT_W'(b);
                end
            end
        end
    end

    assign pos_sum = SUM_W'(base_reg) + SUM_W'(bit_pos);

    assign status.hit       = |cand;
    assign status.last_word = (step_reg == IDX_W'(WORDS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            res_found_reg <= |cand;
            res_pos_reg   <= (|cand) ? pos_sum[POSITION_W-1:0] : '0;
        end
        if (cmd.load_out) begin
            out_reg.found    <= res_found_reg;
            out_reg.position <= res_pos_reg;
        end
    end

    assign m_payload = out_reg;

    a_miss_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && !status.hit) |=> (!res_found_reg && res_pos_reg == '0))
        else $error("miss did not report position zero");

endmodule

>>> rtl/bitmap_first_last_bit_search.sv
// top level of the bitmap first and last bit search
`timescale 1ns / 1ps

// Holds a bitmap of WORDS words of WORD_BITS bits (8 x 32 here). A write request
// stores one word and gives no result. A query request (first set, first clear,
// last set, last clear over bits 0 to bit_count-1) scans the bitmap one word per
// cycle from the bottom or top word, stopping at the first word with a match or
// at the last word, then moves the answer into the output register once it is
// free; the next request is taken only after that move, since the scan walks the
// single bitmap read port. The input side accepts a new request while a finished
// result waits.
module bitmap_first_last_bit_search (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bflb_pkg::s_payload_t  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bflb_pkg::m_payload_t  m_payload
);
    import bflb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bflb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_payload.opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bflb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .status    (status),
        .m_payload (m_payload)
    );

endmodule

>>> bench/testbench.sv
// testbench for the bitmap first and last bit search, checked against a bit-level predictor
`timescale 1ns / 1ps

module testbench;
    import bflb_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_OFF_LEN = 300;
    localparam int PRESSURE_ITEMS = 30;

    typedef struct packed {
        s_payload_t req;
        logic       given;
        m_payload_t answer;
    } directed_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    s_payload_t s_payload;
    logic       m_valid;
    logic       m_ready;
    m_payload_t m_payload;

    logic [WORD_BITS-1:0] bitmap_mirror [WORDS];
    m_payload_t           pending_answers [$];
    int                   mismatch_count;
    int                   sender_idle_pct;
    int                   recv_stall_pct;
    int                   hold_off_cycles;
    int unsigned          cycle_count;

    directed_row_t directed_rows [0:24] = '{
        '{'{OP_FIRST_SET,   3'd0, 32'h0000_0000, 9'd256}, 1'b1, '{1'b0, 8'd0}},
        '{'{OP_FIRST_CLEAR, 3'd0, 32'h0000_0000, 9'd256}, 1'b1, '{1'b1, 8'd0}},
        '{'{OP_LAST_SET,    3'd0, 32'h0000_0000, 9'd256}, 1'b1, '{1'b0, 8'd0}},
        '{'{OP_LAST_CLEAR,  3'd0, 32'h0000_0000, 9'd256}, 1'b1, '{1'b1, 8'd255}},
        '{'{OP_FIRST_CLEAR, 3'd7, 32'hFFFF_FFFF, 9'd0},   1'b1, '{1'b0, 8'd0}},
        '{'{OP_LAST_CLEAR,  3'd0, 32'h0000_0000, 9'd0},   1'b1, '{1'b0, 8'd0}},
        '{'{OP_LAST_CLEAR,  3'd0, 32'h0000_0000, 9'd511}, 1'b1, '{1'b1, 8'd255}},
        '{'{OP_FIRST_SET,   3'd0, 32'h0000_0000, 9'd511}, 1'b1, '{1'b0, 8'd0}},
        '{'{OP_WRITE,       3'd0, 32'hFFFF_FFFF, 9'd0},   1'b0, '{1'b0, 8'd0}},
        '{'{OP_WRITE,       3'd7, 32'h8000_0001, 9'd511}, 1'b0, '{1'b0, 8'd0}},
        '{'{OP_FIRST_SET,   3'd0, 32'h0000_0000, 9'd256}, 1'b1, '{1'b1, 8'd0}},
        '{'{OP_LAST_SET,    3'd0, 32'h0000_0000, 9'd256}, 1'b1, '{1'b1, 8'd255}},
        '{'{OP_LAST_SET,    3'd0, 32'h0000_0000, 9'd255}, 1'b1, '{1'b1, 8'd224}},
        '{'{OP_FIRST_CLEAR, 3'd0, 32'h0000_0000, 9'd32},  1'b1, '{1'b0, 8'd0}},
        '{'{OP_FIRST_CLEAR, 3'd0, 32'h0000_0000, 9'd33},  1'b1, '{1'b1, 8'd32}},
        '{'{OP_LAST_SET,    3'd0, 32'h0000_0000, 9'd1},   1'b1, '{1'b1, 8'd0}},
        '{'{OP_UNUSED_5,    3'd3, 32'h1234_5678, 9'd100}, 1'b0, '{1'b0, 8'd0}},
        '{'{OP_UNUSED_6,    3'd0, 32'h0000_0000, 9'd0},   1'b0, '{1'b0, 8'd0}},
        '{'{OP_UNUSED_7,    3'd7, 32'hFFFF_FFFF, 9'd511}, 1'b0, '{1'b0, 8'd0}},
        '{'{OP_WRITE,       3'd3, 32'h0001_0000, 9'd0},   1'b0, '{1'b0, 8'd0}},
        '{'{OP_LAST_SET,    3'd0, 32'h0000_0000, 9'd224}, 1'b0, '{1'b0, 8'd0}},
        '{'{OP_WRITE,       3'd0, 32'h0000_0000, 9'd0},   1'b0, '{1'b0, 8'd0}},
        '{'{OP_FIRST_SET,   3'd0, 32'h0000_0000, 9'd511}, 1'b0, '{1'b0, 8'd0}},
        '{'{OP_LAST_CLEAR,  3'd0, 32'h0000_0000, 9'd256}, 1'b0, '{1'b0, 8'd0}},
        '{'{OP_FIRST_CLEAR, 3'd0, 32'h0000_0000, 9'd1},   1'b0, '{1'b0, 8'd0}}
    };

    bitmap_first_last_bit_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic m_payload_t search_bitmap(input logic [OPCODE_W-1:0] op,
                                                 input logic [BIT_COUNT_W-1:0] count);
        logic [TOTAL_BITS-1:0] flat;
        logic                  want;
        int                    limit;
        int                    w;
        int                    p;
        m_payload_t            answer;
        answer = '0;
        for (w = 0; w < WORDS; w++) flat[w*WORD_BITS +: WORD_BITS] = bitmap_mirror[w];
        want = (op == OP_FIRST_SET) || (op == OP_LAST_SET);
        limit = (count > TOTAL_BITS) ? TOTAL_BITS : int'(count);
        if (op == OP_LAST_SET || op == OP_LAST_CLEAR) begin
            for (p = limit - 1; p >= 0; p--) begin
                if (flat[p] == want) begin
                    answer.found = 1'b1;
                    answer.position = p[POSITION_W-1:0];
                    return answer;
                end
            end
        end else begin
            for (p = 0; p < limit; p++) begin
                if (flat[p] == want) begin
                    answer.found = 1'b1;
                    answer.position = p[POSITION_W-1:0];
                    return answer;
                end
            end
        end
        return answer;
    endfunction

    function automatic s_payload_t random_request(input bit query_only);
        s_payload_t req;
        int         pick;
        int         shift;
        pick = $urandom_range(99);
        shift = $urandom_range(WORD_BITS - 1);
        if (query_only || (pick >= 30 && pick < 95)) begin
            req.opcode = OPCODE_W'($urandom_range(OP_LAST_CLEAR, OP_FIRST_SET));
        end else if (pick < 30) begin
            req.opcode = OP_WRITE;
        end else begin
            req.opcode = OPCODE_W'($urandom_range(OP_UNUSED_7, OP_UNUSED_5));
        end
        req.word_index = WORD_INDEX_W'($urandom_range(WORDS - 1));
        case ($urandom_range(4))
            0: req.word_data = '0;
            1: req.word_data = '1;
            2: req.word_data = 32'd1 << shift;
            3: req.word_data = ~(32'd1 << shift);
            default: req.word_data = $urandom;
        endcase
        case ($urandom_range(9))
            0: req.bit_count = '0;
            1: req.bit_count = BIT_COUNT_W'($urandom_range(511, 256));
            2: req.bit_count = BIT_COUNT_W'($urandom_range(WORDS) * WORD_BITS);
            3: req.bit_count = $urandom_range(1) ? 9'd255 : 9'd1;
            default: req.bit_count = BIT_COUNT_W'($urandom_range(511));
        endcase
        return req;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic offer_request(input s_payload_t req, input logic given,
                                 input m_payload_t answer);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        if (req.opcode == OP_WRITE) begin
            if (req.word_index < WORDS) bitmap_mirror[req.word_index] = req.word_data[WORD_BITS-1:0];
        end else if (req.opcode <= OP_LAST_CLEAR) begin
            pending_answers.push_back(given ? answer : search_bitmap(req.opcode, req.bit_count));
        end
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // receiver side: random stalls plus long hold-offs counted here
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles != 0) begin
                stall_left = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        m_payload_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result %0b/%0d with no query pending",
                                          m_payload.found, m_payload.position));
            end else begin
                want = pending_answers.pop_front();
                if (m_payload.found !== want.found)
                    report_mismatch($sformatf("found %0b, predicted %0b",
                                              m_payload.found, want.found));
                if (m_payload.position !== want.position)
                    report_mismatch($sformatf("position %0d, predicted %0d",
                                              m_payload.position, want.position));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int         sender_pcts [4] = '{0, 75, 0, 35};
        int         recv_pcts [4] = '{0, 0, 75, 35};
        int         phase;
        int         sent;
        int         i;
        s_payload_t req;
        cycle_count = 0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        for (i = 0; i < WORDS; i++) bitmap_mirror[i] = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_payload <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            offer_request(directed_rows[r].req, directed_rows[r].given, directed_rows[r].answer);

        for (phase = 0; phase < 4; phase++) begin
            sender_idle_pct = sender_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                req = random_request(1'b0);
                offer_request(req, 1'b0, '0);
                sent++;
            end
            if (phase == 0) begin
                // long receiver hold-off while queries keep coming
                hold_off_cycles = HOLD_OFF_LEN;
                for (i = 0; i < PRESSURE_ITEMS; i++) offer_request(random_request(1'b1), 1'b0, '0);
                s_valid <= 1'b0;
                wait_drained();
            end
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
